FILE: sv/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types, constants and per-byte helper functions for the CSV field
// splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

  localparam int MAX_LINE_BYTES = 65536;
  localparam int POS_W  = $clog2(MAX_LINE_BYTES + 1);  // byte position, holds the limit
  localparam int TPOS_W = $clog2(MAX_LINE_BYTES);      // position of a tracked byte
  localparam int OFF_W  = 16;
  localparam int LEN_W  = 17;
  localparam int BYTE_W = 8;
  localparam int DATA_W = 40;                          // offset + length, byte padded

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

  localparam logic [BYTE_W-1:0] SEP_RESET   = 8'd44;
  localparam logic [BYTE_W-1:0] QUOTE_RESET = 8'd34;

  localparam logic REG_SEPARATOR = 1'b0;
  localparam logic REG_QUOTE     = 1'b1;

  // Trackers of the field being collected.
  typedef struct packed {
    logic [POS_W-1:0]            fbegin;
    logic [BYTE_W-1:0]           first_byte;
    logic [1:0]                  fn_seen;
    logic [1:0][TPOS_W-1:0]      fn_pos;    // [0] from field start, [1] one byte later
    logic [1:0]                  ln_seen;
    logic [1:0][TPOS_W-1:0]      ln_pos;    // [0] inclusive, [1] before last non-newline
    logic                        lnn_seen;
    logic [TPOS_W-1:0]           lnn_pos;
    logic [BYTE_W-1:0]           lnn_byte;
  } field_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic             quoted;
    logic             last;
  } result_t;

  function automatic logic is_blank(logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_newline(logic [BYTE_W-1:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic field_t field_clear(logic [POS_W-1:0] start);
    field_t f;
    f = '0;
    f.fbegin = start;
    return f;
  endfunction

  function automatic field_t field_track(field_t fs, logic [BYTE_W-1:0] c,
                                         logic [TPOS_W-1:0] p);
    field_t            t;
    logic [POS_W-1:0]  pw;
    logic [TPOS_W-1:0] prev_pos;
    logic              prev_seen;
    t  = fs;
    pw = {1'b0, p};
    if (pw == fs.fbegin) t.first_byte = c;
    if (!fs.fn_seen[0] && pw >= fs.fbegin && !is_blank(c)) begin
      t.fn_seen[0] = 1'b1;
      t.fn_pos[0]  = p;
    end
    if (!fs.fn_seen[1] && pw > fs.fbegin && !is_blank(c)) begin
      t.fn_seen[1] = 1'b1;
      t.fn_pos[1]  = p;
    end
    if (!is_newline(c)) begin
      prev_pos  = fs.ln_pos[0];
      prev_seen = fs.ln_seen[0];
      // a newline right before this byte counts as content
      if (pw > fs.fbegin && (!fs.lnn_seen || ({1'b0, fs.lnn_pos} + POS_W'(1)) != pw)) begin
        prev_pos  = p - TPOS_W'(1);
        prev_seen = 1'b1;
      end
      t.ln_pos[1]  = prev_pos;
      t.ln_seen[1] = prev_seen;
      if (!is_blank(c)) begin
        t.ln_pos[0]  = p;
        t.ln_seen[0] = 1'b1;
      end else begin
        t.ln_pos[0]  = prev_pos;
        t.ln_seen[0] = prev_seen;
      end
      t.lnn_seen = 1'b1;
      t.lnn_pos  = p;
      t.lnn_byte = c;
    end
    return t;
  endfunction

  function automatic result_t field_emit(field_t fs, logic [BYTE_W-1:0] qc, logic last);
    result_t          r;
    logic [POS_W-1:0] fend;
    logic [POS_W-1:0] fsize;
    logic [POS_W-1:0] stop;
    logic [POS_W-1:0] fn;
    logic [POS_W-1:0] ln;
    logic             q;
    fend  = fs.lnn_seen ? ({1'b0, fs.lnn_pos} + POS_W'(1)) : fs.fbegin;
    fsize = fend - fs.fbegin;
    q     = (fsize >= POS_W'(2)) && (fs.first_byte == qc) && (fs.lnn_byte == qc);
    stop  = fend - POS_W'(q);
    fn    = {1'b0, fs.fn_pos[q]};
    ln    = {1'b0, fs.ln_pos[q]};
    r.quoted = q;
    r.last   = last;
    if (fs.fn_seen[q] && fn < stop && fs.ln_seen[q] && ln >= fn) begin
      r.offset = fn[OFF_W-1:0];
      r.length = LEN_W'(ln - fn) + LEN_W'(1);
    end else begin
      r.offset = stop[OFF_W-1:0];
      r.length = '0;
    end
    return r;
  endfunction

endpackage

FILE: sv/csv_field_splitter.sv
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a byte stream of delimited text lines into field descriptors.
// ----------------------------------------------------------------------------
// A field descriptor enters a four-entry result queue when the byte that closes it is accepted.
// Throughput: one byte per cycle while the queue has two free entries; a separator on the last
//   byte of a line gives two descriptors, drained one per cycle while m_tready is high.
// Reset (rst, synchronous): separator 44, quote 34, line state cleared, queue empty.
module csv_field_splitter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [csvfs_pkg::BYTE_W-1:0]      cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [csvfs_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] line_byte
  input  logic                              s_tlast,   // line_end
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [csvfs_pkg::DATA_W-1:0]      m_tdata,   // [15:0] field_offset, [32:16] field_length
  output logic                              m_tuser,   // field_quoted
  output logic                              m_tlast    // field_last
);

  logic [csvfs_pkg::BYTE_W-1:0]    sep;
  logic [csvfs_pkg::BYTE_W-1:0]    quote;
  logic                            inq;
  logic                            qpend;
  logic                            alb;
  logic [csvfs_pkg::POS_W-1:0]     bpos;
  csvfs_pkg::field_t               fs;

  csvfs_pkg::result_t              resq [csvfs_pkg::RES_DEPTH];
  logic [csvfs_pkg::RES_PTR_W-1:0] wptr;
  logic [csvfs_pkg::RES_PTR_W-1:0] rptr;
  logic [csvfs_pkg::RES_CNT_W-1:0] cnt;

  logic                            accept;
  logic                            pop;
  logic                            active;
  logic                            handled;
  logic                            splits;
  logic                            inq_next;
  logic                            qpend_next;
  logic                            alb_next;
  csvfs_pkg::field_t               fs_tracked;
  csvfs_pkg::field_t               fs_next;
  csvfs_pkg::result_t              res0;
  csvfs_pkg::result_t              res1;
  logic [csvfs_pkg::POS_W-1:0]     bpos_inc;
  logic [1:0]                      nres;
  csvfs_pkg::result_t              head;

  assign s_tready = cnt <= csvfs_pkg::RES_CNT_W'(csvfs_pkg::RES_DEPTH - 2);
  assign accept   = s_tvalid & s_tready;
  assign m_tvalid = cnt != '0;
  assign pop      = m_tvalid & m_tready;

  assign active   = bpos < csvfs_pkg::POS_W'(csvfs_pkg::MAX_LINE_BYTES);
  assign bpos_inc = bpos + csvfs_pkg::POS_W'(1);

  // quote / separator / newline decisions for the incoming byte
  always_comb begin
    handled    = 1'b0;
    splits     = 1'b0;
    inq_next   = inq;
    qpend_next = qpend;
    alb_next   = alb;
    if (active) begin
      if (qpend) begin
        qpend_next = 1'b0;
        if (s_tdata == quote) handled = 1'b1;   // doubled quote
        else inq_next = 1'b0;
      end
      if (!handled && !alb) begin
        if (s_tdata == quote) begin
          if (inq_next) begin
            if (s_tlast) inq_next = 1'b0;
            else qpend_next = 1'b1;
          end else begin
            inq_next = 1'b1;
          end
        end else if (!inq_next) begin
          if (s_tdata == sep) splits = 1'b1;
          else if (csvfs_pkg::is_newline(s_tdata)) alb_next = 1'b1;
        end
      end
    end
  end

  assign fs_tracked = csvfs_pkg::field_track(fs, s_tdata, bpos[csvfs_pkg::TPOS_W-1:0]);

  always_comb begin
    if (!active) fs_next = fs;
    else if (splits) fs_next = csvfs_pkg::field_clear(bpos_inc);
    else fs_next = fs_tracked;
  end

  // with a split, the line's final field (if any) is empty at the next position
  always_comb begin
    res0 = csvfs_pkg::field_emit(splits ? fs : fs_next, quote, !splits);
    res1.offset = bpos_inc[csvfs_pkg::OFF_W-1:0];
    res1.length = '0;
    res1.quoted = 1'b0;
    res1.last   = 1'b1;
    if (splits) nres = s_tlast ? 2'd2 : 2'd1;
    else nres = s_tlast ? 2'd1 : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep   <= csvfs_pkg::SEP_RESET;
      quote <= csvfs_pkg::QUOTE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        csvfs_pkg::REG_SEPARATOR: sep   <= cfg_wdata;
        csvfs_pkg::REG_QUOTE:     quote <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq   <= 1'b0;
      qpend <= 1'b0;
      alb   <= 1'b0;
      bpos  <= '0;
      fs    <= csvfs_pkg::field_clear('0);
    end else if (accept) begin
      if (s_tlast) begin
        inq   <= 1'b0;
        qpend <= 1'b0;
        alb   <= 1'b0;
        bpos  <= '0;
        fs    <= csvfs_pkg::field_clear('0);
      end else begin
        inq   <= inq_next;
        qpend <= qpend_next;
        alb   <= alb_next;
        bpos  <= active ? bpos_inc : bpos;
        fs    <= fs_next;
      end
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (accept && nres != 2'd0) resq[wptr] <= res0;
    if (accept && nres == 2'd2) resq[wptr + csvfs_pkg::RES_PTR_W'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (accept) wptr <= wptr + csvfs_pkg::RES_PTR_W'(nres);
      if (pop) rptr <= rptr + csvfs_pkg::RES_PTR_W'(1);
      cnt <= cnt + csvfs_pkg::RES_CNT_W'(accept ? nres : 2'd0)
                 - csvfs_pkg::RES_CNT_W'(pop);
    end
  end

  assign head    = resq[rptr];
  assign m_tdata = {(csvfs_pkg::DATA_W - csvfs_pkg::OFF_W - csvfs_pkg::LEN_W)'(0),
                    head.length, head.offset};
  assign m_tuser = head.quoted;
  assign m_tlast = head.last;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for csv_field_splitter. Lines of bytes go in on the
// slave stream and every field descriptor that comes out is compared with a
// bit-accurate line parser kept here. A short table of hand-made lines runs
// first. Random lines follow under several separator/quote settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_BYTES  = 165;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIR_ROWS     = 26;
  localparam int N_SETS       = 8;

  typedef struct packed {
    logic [15:0] offset;
    logic [16:0] length;
    logic        quoted;
    logic        last;
  } field_rec_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eol;
    logic       typed;
    field_rec_t want;
  } dir_row_t;

  localparam logic [7:0] CH_Q = 8'h22;  // default quote
  localparam logic [7:0] CH_S = 8'h2C;  // default separator

  // Hand-made lines under the reset settings; typed rows give one field each.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{8'h61, 1'b1, 1'b1, '{16'd0, 17'd1, 1'b0, 1'b1}},
    // separator on the last byte: two fields
    '{CH_S,  1'b1, 1'b0, '0},
    '{CH_Q,  1'b0, 1'b0, '0},
    '{8'h78, 1'b0, 1'b0, '0},
    '{CH_Q,  1'b1, 1'b1, '{16'd1, 17'd1, 1'b1, 1'b1}},
    // all-blank field, then a 0xff field
    '{csvfs_pkg::CH_SPACE, 1'b0, 1'b0, '0},
    '{csvfs_pkg::CH_TAB,   1'b0, 1'b0, '0},
    '{CH_S,  1'b0, 1'b1, '{16'd2, 17'd0, 1'b0, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{16'd3, 17'd1, 1'b0, 1'b1}},
    // after an unquoted CR the separator is plain content
    '{8'h00, 1'b0, 1'b0, '0},
    '{csvfs_pkg::CH_CR, 1'b0, 1'b0, '0},
    '{8'h78, 1'b0, 1'b0, '0},
    '{CH_S,  1'b0, 1'b0, '0},
    '{8'h79, 1'b1, 1'b1, '{16'd0, 17'd5, 1'b0, 1'b1}},
    // trailing CR LF stripped
    '{8'h7A, 1'b0, 1'b0, '0},
    '{csvfs_pkg::CH_CR, 1'b0, 1'b0, '0},
    '{csvfs_pkg::CH_LF, 1'b1, 1'b1, '{16'd0, 17'd1, 1'b0, 1'b1}},
    // escaped quote, closing quote on the last byte
    '{CH_Q,  1'b0, 1'b0, '0},
    '{CH_Q,  1'b0, 1'b0, '0},
    '{CH_Q,  1'b0, 1'b0, '0},
    '{CH_Q,  1'b1, 1'b1, '{16'd1, 17'd2, 1'b1, 1'b1}},
    // separator inside quotes, pending quote resolved by a separator
    '{CH_Q,  1'b0, 1'b0, '0},
    '{CH_S,  1'b0, 1'b0, '0},
    '{CH_Q,  1'b0, 1'b0, '0},
    '{CH_S,  1'b0, 1'b1, '{16'd1, 17'd1, 1'b1, 1'b0}},
    '{8'h61, 1'b1, 1'b1, '{16'd4, 17'd1, 1'b0, 1'b1}}
  };

  // {separator, quote}; extremes, quote == separator, quote == LF, sep == CR/space
  localparam logic [15:0] CHAR_SETS [N_SETS] = '{
    16'h0927, 16'h00FF, 16'hFF00, 16'h2C2C, 16'h3B0A, 16'h0D22, 16'h2022, 16'h2C22
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_addr  = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;   // [7:0] line_byte
  logic        s_tlast   = 1'b0; // line_end
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;          // [15:0] field_offset, [32:16] field_length
  logic        m_tuser;          // field_quoted
  logic        m_tlast;          // field_last

  csv_field_splitter u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  // ---------------- line parser state ----------------
  logic [7:0]  cfg_sep, cfg_quote;
  logic        in_quotes, quote_wait, past_break;
  int unsigned pos, fld_begin;
  logic [7:0]  fld_first;
  int unsigned fnb_pos [2];
  logic        fnb_seen [2];
  int unsigned lnb_pos [2];
  logic        lnb_seen [2];
  int unsigned lnl_pos;
  logic [7:0]  lnl_byte;
  logic        lnl_seen;

  field_rec_t  expected_fields [$];
  logic [7:0]  line_bytes [$];
  int          mismatches = 0;
  logic        steady     = 1'b0;
  logic        hold_req   = 1'b0;

  function automatic logic blank_byte(input logic [7:0] c);
    return c == csvfs_pkg::CH_SPACE || c == csvfs_pkg::CH_TAB;
  endfunction

  function automatic logic break_byte(input logic [7:0] c);
    return c == csvfs_pkg::CH_CR || c == csvfs_pkg::CH_LF;
  endfunction

  function automatic void add_field(input field_rec_t r);
    expected_fields.insert(expected_fields.size(), r);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    line_bytes.insert(line_bytes.size(), b);
  endfunction

  function automatic void start_field(input int unsigned at);
    fld_begin = at;
    fld_first = '0;
    for (int v = 0; v < 2; v++) begin
      fnb_pos[v]  = 0;
      fnb_seen[v] = 1'b0;
      lnb_pos[v]  = 0;
      lnb_seen[v] = 1'b0;
    end
    lnl_pos  = 0;
    lnl_byte = '0;
    lnl_seen = 1'b0;
  endfunction

  function automatic void start_line();
    in_quotes  = 1'b0;
    quote_wait = 1'b0;
    past_break = 1'b0;
    pos        = 0;
    start_field(0);
  endfunction

  function automatic void note_byte(input logic [7:0] c, input int unsigned p);
    int unsigned prev_pos;
    logic        prev_seen;
    if (p == fld_begin) fld_first = c;
    for (int v = 0; v < 2; v++) begin
      if (!fnb_seen[v] && p >= fld_begin + v && !blank_byte(c)) begin
        fnb_seen[v] = 1'b1;
        fnb_pos[v]  = p;
      end
    end
    if (!break_byte(c)) begin
      prev_pos  = lnb_pos[0];
      prev_seen = lnb_seen[0];
      // a line break right before this byte is kept as content
      if (p > fld_begin && (!lnl_seen || lnl_pos + 1 != p)) begin
        prev_pos  = p - 1;
        prev_seen = 1'b1;
      end
      lnb_pos[1]  = prev_pos;
      lnb_seen[1] = prev_seen;
      if (!blank_byte(c)) begin
        lnb_pos[0]  = p;
        lnb_seen[0] = 1'b1;
      end else begin
        lnb_pos[0]  = prev_pos;
        lnb_seen[0] = prev_seen;
      end
      lnl_pos  = p;
      lnl_byte = c;
      lnl_seen = 1'b1;
    end
  endfunction

  function automatic void close_field(input logic last);
    int unsigned fend, stop, off, len;
    int          q;
    field_rec_t  r;
    fend     = lnl_seen ? lnl_pos + 1 : fld_begin;
    r.quoted = (fend - fld_begin >= 2) && fld_first == cfg_quote && lnl_byte == cfg_quote;
    q        = r.quoted;
    stop     = fend - q;
    off      = stop;
    len      = 0;
    if (fnb_seen[q] && fnb_pos[q] < stop && lnb_seen[q] && lnb_pos[q] >= fnb_pos[q]) begin
      off = fnb_pos[q];
      len = lnb_pos[q] - off + 1;
    end
    r.offset = off[15:0];
    r.length = len[16:0];
    r.last   = last;
    add_field(r);
  endfunction

  function automatic void predict_byte(input logic [7:0] c, input logic eol);
    int unsigned p;
    logic        escaped, splits;
    p = pos;
    if (p < csvfs_pkg::MAX_LINE_BYTES) begin
      escaped = 1'b0;
      splits  = 1'b0;
      if (quote_wait) begin
        quote_wait = 1'b0;
        if (c == cfg_quote) escaped = 1'b1;
        else in_quotes = 1'b0;
      end
      if (!escaped && !past_break) begin
        if (c == cfg_quote) begin
          if (in_quotes) begin
            if (eol) in_quotes = 1'b0;
            else quote_wait = 1'b1;
          end else begin
            in_quotes = 1'b1;
          end
        end else if (!in_quotes) begin
          if (c == cfg_sep) splits = 1'b1;
          else if (break_byte(c)) past_break = 1'b1;
        end
      end
      if (splits) begin
        close_field(1'b0);
        start_field(p + 1);
      end else begin
        note_byte(c, p);
      end
      pos = p + 1;
    end
    if (eol) begin
      close_field(1'b1);
      start_line();
    end
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $realtime, what);
  endtask

  task automatic check_field();
    field_rec_t want;
    if (expected_fields.size() == 0) begin
      report_mismatch($sformatf("field with nothing expected, offset %0d length %0d",
                                m_tdata[15:0], m_tdata[32:16]));
      return;
    end
    want = expected_fields.pop_front();
    if (m_tdata[15:0] != want.offset)
      report_mismatch($sformatf("offset %0d, want %0d", m_tdata[15:0], want.offset));
    if (m_tdata[32:16] != want.length)
      report_mismatch($sformatf("length %0d, want %0d", m_tdata[32:16], want.length));
    if (m_tuser != want.quoted)
      report_mismatch($sformatf("quoted %0b, want %0b", m_tuser, want.quoted));
    if (m_tlast != want.last)
      report_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
  endtask

  // Receiver: random back-pressure, one long hold-off on request.
  initial begin : field_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_field();
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 14);
      end
    end
  end

  // ---------------- stimulus ----------------
  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic eol);
    while (!steady && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eol;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_byte(b, eol);
    @(negedge clk);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_bytes.size(); i++)
      send_byte(line_bytes[i], i == line_bytes.size() - 1);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_fields.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_chars(input logic [7:0] sep, input logic [7:0] quote);
    cfg_we    <= 1'b1;
    cfg_addr  <= csvfs_pkg::REG_SEPARATOR;
    cfg_wdata <= sep;
    @(negedge clk);
    cfg_addr  <= csvfs_pkg::REG_QUOTE;
    cfg_wdata <= quote;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_sep   = sep;
    cfg_quote = quote;
  endtask

  function automatic logic [7:0] text_byte();
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [7:0] any_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return cfg_sep;
    if (roll < 30) return cfg_quote;
    if (roll < 45) return roll[0] ? csvfs_pkg::CH_SPACE : csvfs_pkg::CH_TAB;
    if (roll < 52) return roll[0] ? csvfs_pkg::CH_CR : csvfs_pkg::CH_LF;
    if (roll < 62) return 8'($urandom_range(255));
    return text_byte();
  endfunction

  task automatic add_blanks();
    repeat ($urandom_range(0, 2))
      add_byte($urandom_range(1) ? csvfs_pkg::CH_SPACE : csvfs_pkg::CH_TAB);
  endtask

  // Mostly well-formed records with random content; some raw noise lines.
  task automatic make_line();
    int nfields;
    line_bytes.delete();
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 24)) add_byte(any_byte());
    end else begin
      nfields = $urandom_range(1, 5);
      for (int f = 0; f < nfields; f++) begin
        if (f > 0) add_byte(cfg_sep);
        add_blanks();
        if ($urandom_range(1)) begin
          add_byte(cfg_quote);
          repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(9))
              0: begin
                add_byte(cfg_quote);
                add_byte(cfg_quote);
              end
              1: add_byte(cfg_sep);
              2: add_byte($urandom_range(1) ? csvfs_pkg::CH_CR : csvfs_pkg::CH_LF);
              3: add_byte(csvfs_pkg::CH_SPACE);
              default: add_byte(text_byte());
            endcase
          end
          // unterminated quote now and then
          if ($urandom_range(9) != 0) add_byte(cfg_quote);
        end else begin
          repeat ($urandom_range(0, 6))
            add_byte($urandom_range(4) == 0 ? csvfs_pkg::CH_SPACE : text_byte());
        end
        add_blanks();
      end
      case ($urandom_range(9))
        0: begin
          add_byte(csvfs_pkg::CH_CR);
          add_byte(csvfs_pkg::CH_LF);
        end
        1: add_byte(csvfs_pkg::CH_LF);
        2: add_byte(cfg_sep);
        3: begin
          add_byte(csvfs_pkg::CH_CR);
          repeat ($urandom_range(1, 5)) add_byte(any_byte());
        end
        default: ;
      endcase
    end
    if (line_bytes.size() == 0) add_byte(text_byte());
  endtask

  initial begin : stimulus
    int sent;
    cfg_sep   = csvfs_pkg::SEP_RESET;
    cfg_quote = csvfs_pkg::QUOTE_RESET;
    start_line();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(dir_rows[i].data, dir_rows[i].eol);
      // the DUT queues this field, so it is not checked yet and can still be replaced
      if (dir_rows[i].typed) expected_fields[expected_fields.size() - 1] = dir_rows[i].want;
    end

    for (int k = 0; k < N_SETS; k++) begin
      settle();
      load_chars(CHAR_SETS[k][15:8], CHAR_SETS[k][7:0]);
      steady = (k == 3);
      if (k == 1) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        make_line();
        send_line();
        sent += line_bytes.size();
      end
    end
    steady = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
